[rtl/core/rnsfbc_pkg.sv]
`timescale 1ns / 1ps
package rnsfbc_pkg;
    localparam int unsigned MODULUS_BITS_DEF = 61;
    localparam int unsigned QUEUE_DEPTH = 2;

    // One term after the Shoup stage, as handed from front to back.
    typedef struct packed {
        logic [63:0] y;
        logic [63:0] hat;
        logic        last;
    } t_term;

    typedef enum logic [2:0] {
        F_IDLE,
        F_QUOT,
        F_LOW,
        F_QP,
        F_FIX
    } t_front_state;

    typedef enum logic [1:0] {
        T_IDLE,
        T_MUL,
        T_ACC
    } t_back_state;
endpackage

[rtl/core/rnsfbc_front.sv]
`timescale 1ns / 1ps
module rnsfbc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [60:0]              i_residue,
    input  logic [60:0]              i_src_modulus,
    input  logic [60:0]              i_inv_hat,
    input  logic [63:0]              i_inv_hat_shoup,
    input  logic [60:0]              i_hat_in_dst,
    input  logic                     i_last_term,
    output logic                     o_term_valid,
    input  logic                     i_term_ready,
    output rnsfbc_pkg::t_term        o_term
);
    import rnsfbc_pkg::*;

    // Three 64x64 products are formed one after another, each from four
    // 32x32 partial products, one per cycle.
    t_front_state r_state, n_state;
    logic [1:0]   r_step;
    logic [63:0]  r_x;
    logic [63:0]  r_c;
    logic [63:0]  r_cs;
    logic [63:0]  r_p;
    logic [63:0]  r_hat;
    logic         r_last;
    logic [127:0] r_acc;
    logic [63:0]  r_q;
    logic [63:0]  r_xc;
    logic [63:0]  r_qp;
    // Output register.
    logic         r_term_valid;
    t_term        r_term;

    logic         out_free;
    logic         accept;
    logic         advance;
    logic         finish;
    logic [63:0]  op_a;
    logic [63:0]  op_b;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] prod;
    logic [63:0]  t_val;

    assign out_free = !r_term_valid || i_term_ready;
    assign o_stall  = (r_state != F_IDLE);
    assign accept   = (r_state == F_IDLE) && i_valid;
    assign finish   = (r_state == F_FIX) && out_free;
    assign mul_a    = r_step[1] ? op_a[63:32] : op_a[31:0];
    assign mul_b    = r_step[0] ? op_b[63:32] : op_b[31:0];
    assign pp       = 64'(mul_a) * 64'(mul_b);
    assign prod     = ((r_step == 2'd0) ? 128'd0 : r_acc) + pp_sh;
    assign t_val    = r_xc - r_qp;

    always_comb begin
        case (r_step)
            2'd0: pp_sh = {64'd0, pp};
            2'd3: pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    always_comb begin
        n_state = r_state;
        advance = 1'b0;
        op_a    = r_x;
        op_b    = r_cs;
        case (r_state)
            F_IDLE: begin
                if (i_valid) n_state = F_QUOT;
            end
            F_QUOT: begin
                advance = 1'b1;
                if (r_step == 2'd3) n_state = F_LOW;
            end
            F_LOW: begin
                op_b    = r_c;
                advance = 1'b1;
                if (r_step == 2'd3) n_state = F_QP;
            end
            F_QP: begin
                op_a    = r_q;
                op_b    = r_p;
                advance = 1'b1;
                if (r_step == 2'd3) n_state = F_FIX;
            end
            F_FIX: begin
                if (out_free) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_step       <= 2'd0;
            r_term_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) r_step <= r_step + 2'd1;
            if (finish) r_term_valid <= 1'b1;
            else if (i_term_ready) r_term_valid <= 1'b0;
        end
        if (accept) begin
            r_x    <= {3'd0, i_residue};
            r_c    <= {3'd0, i_inv_hat};
            r_cs   <= i_inv_hat_shoup;
            r_p    <= {3'd0, i_src_modulus};
            r_hat  <= {3'd0, i_hat_in_dst};
            r_last <= i_last_term;
        end
        if (advance) r_acc <= prod;
        if (r_state == F_QUOT && r_step == 2'd3) r_q  <= prod[127:64];
        if (r_state == F_LOW && r_step == 2'd3)  r_xc <= prod[63:0];
        if (r_state == F_QP && r_step == 2'd3)   r_qp <= prod[63:0];
        if (finish) begin
            r_term.y    <= (t_val < r_p) ? t_val : t_val - r_p;
            r_term.hat  <= r_hat;
            r_term.last <= r_last;
        end
    end

    assign o_term_valid = r_term_valid;
    assign o_term       = r_term;
endmodule

[rtl/core/rnsfbc_queue.sv]
`timescale 1ns / 1ps
module rnsfbc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rnsfbc_pkg::t_term i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output rnsfbc_pkg::t_term o_data
);
    import rnsfbc_pkg::*;

    t_term r_mem [QUEUE_DEPTH];
    logic  r_wp;
    logic  r_rp;
    logic [1:0] r_cnt;
    logic  push;
    logic  pop;

    assign o_ready = (r_cnt != 2'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_mem[r_wp] <= i_data;
    end
endmodule

[rtl/core/rnsfbc_back.sv]
`timescale 1ns / 1ps
module rnsfbc_back #(
    parameter int unsigned MODULUS_BITS = rnsfbc_pkg::MODULUS_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_term_valid,
    output logic                    o_term_ready,
    input  rnsfbc_pkg::t_term       i_term,
    input  logic [MODULUS_BITS-1:0] i_dst,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [60:0]             o_converted
);
    import rnsfbc_pkg::*;

    t_back_state  r_state, n_state;
    // The product is built from four 32x32 partial products, one per cycle.
    logic [1:0]   r_step;
    logic [63:0]  r_y;
    logic [63:0]  r_hat;
    logic [127:0] r_prod;
    logic         r_last;
    logic [127:0] r_acc;
    // Bit-serial reduction: one accumulator bit per cycle while no result is held.
    logic         r_red;
    logic [6:0]   r_bit;
    logic [127:0] r_sh;
    logic [MODULUS_BITS:0] r_rem;
    logic         r_oval;
    logic [60:0]  r_out;

    logic [MODULUS_BITS:0] rem2;
    logic [MODULUS_BITS:0] dst_x;
    logic [MODULUS_BITS:0] rem_n;
    logic         take;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] prod_n;

    assign dst_x = {1'b0, i_dst};
    assign rem2  = {r_rem[MODULUS_BITS-1:0], r_sh[127]};
    // Carry out of the shift means the value is at least 2^MODULUS_BITS > dst.
    assign rem_n = (r_rem[MODULUS_BITS-1] || rem2 >= dst_x) ? rem2 - dst_x : rem2;

    assign take   = (r_state == T_IDLE) && i_term_valid && !r_red;
    assign mul_a  = r_step[1] ? r_y[63:32] : r_y[31:0];
    assign mul_b  = r_step[0] ? r_hat[63:32] : r_hat[31:0];
    assign pp     = 64'(mul_a) * 64'(mul_b);
    assign prod_n = ((r_step == 2'd0) ? 128'd0 : r_prod) + pp_sh;

    always_comb begin
        case (r_step)
            2'd0: pp_sh = {64'd0, pp};
            2'd3: pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    always_comb begin
        n_state      = r_state;
        o_term_ready = 1'b0;
        case (r_state)
            T_IDLE: begin
                o_term_ready = !r_red;
                if (i_term_valid && !r_red) n_state = T_MUL;
            end
            T_MUL: begin
                if (r_step == 2'd3) n_state = T_ACC;
            end
            T_ACC: n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_step  <= 2'd0;
            r_acc   <= '0;
            r_red   <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == T_MUL) r_step <= r_step + 2'd1;
            if (r_oval && !i_stall) r_oval <= 1'b0;
            if (r_state == T_ACC) begin
                if (r_last) begin
                    r_sh  <= r_acc + r_prod;
                    r_acc <= '0;
                    r_red <= 1'b1;
                    r_bit <= 7'd127;
                    r_rem <= '0;
                end else begin
                    r_acc <= r_acc + r_prod;
                end
            end
            if (r_red && !r_oval) begin
                r_rem <= rem_n;
                r_sh  <= {r_sh[126:0], 1'b0};
                r_bit <= r_bit - 7'd1;
                if (r_bit == 7'd0) begin
                    r_red  <= 1'b0;
                    r_oval <= 1'b1;
                    r_out  <= (i_dst < MODULUS_BITS'(2)) ? 61'd0
                              : 61'({1'b0, rem_n[MODULUS_BITS-1:0]});
                end
            end
        end
        if (take) begin
            r_y    <= i_term.y;
            r_hat  <= i_term.hat;
            r_last <= i_term.last;
        end
        if (r_state == T_MUL) r_prod <= prod_n;
    end

    assign o_valid     = r_oval;
    assign o_converted = r_out;
endmodule

[rtl/core/rns_fast_basis_conversion_core.sv]
`timescale 1ns / 1ps
// RNS fast base conversion to one destination modulus.
// Input channel: i_valid / o_stall; one beat is one source term of a
// coefficient (residue, source prime, inverse punctured product and its Shoup
// quotient, punctured product mod the destination, and a last-term flag).
// Output channel: o_valid / i_stall; one beat per coefficient, carrying the
// accumulated sum reduced modulo the destination prime.
// Configuration: i_cfg_valid / o_cfg_ready writes dst_modulus; it is always
// ready and must only be written while no term or result is in flight.
// The front forms the three Shoup products with one 32x32 multiplier, each
// from four partial products, then corrects the remainder; it takes a new
// term only once the last is corrected and handed on. A two-entry queue
// feeds the back part, which forms y times the punctured product the same
// way, then adds it to the sum, taking one term at a time. On a last term
// the sum is reduced bit-serially, one accumulator bit per cycle while no
// result is held, and the back part takes no terms during the reduction.
// A stalled result holds in the output register; a following reduction then
// waits at its first bit. o_stall is high while the front holds a term.
// Synchronous active-low reset clears the accumulator, all valid flags and
// sets dst_modulus to 2^61-1 (truncated to MODULUS_BITS).
module rns_fast_basis_conversion_core #(
    parameter int unsigned MODULUS_BITS = rnsfbc_pkg::MODULUS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [60:0] i_residue,
    input  logic [60:0] i_src_modulus,
    input  logic [60:0] i_inv_hat,
    input  logic [63:0] i_inv_hat_shoup,
    input  logic [60:0] i_hat_in_dst,
    input  logic        i_last_term,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [60:0] i_cfg_dst_modulus,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [60:0] o_converted
);
    import rnsfbc_pkg::*;

    logic [MODULUS_BITS-1:0] r_dst;
    logic  f_valid, f_ready, q_valid, q_ready;
    t_term f_term, q_term;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst <= MODULUS_BITS'(61'h1FFF_FFFF_FFFF_FFFF);
        end else if (i_cfg_valid) begin
            r_dst <= MODULUS_BITS'(i_cfg_dst_modulus);
        end
    end

    rnsfbc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_residue, .i_src_modulus, .i_inv_hat, .i_inv_hat_shoup,
        .i_hat_in_dst, .i_last_term,
        .o_term_valid(f_valid), .i_term_ready(f_ready), .o_term(f_term)
    );

    rnsfbc_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_data(f_term),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_term)
    );

    rnsfbc_back #(.MODULUS_BITS(MODULUS_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_term_valid(q_valid), .o_term_ready(q_ready), .i_term(q_term),
        .i_dst(r_dst), .o_valid, .i_stall, .o_converted
    );
endmodule

[rtl/core/rnsfbc_checker.sv]
`timescale 1ns / 1ps
module rnsfbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [60:0] o_converted
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_converted))
        else $error("result changed while stalled");
    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
    a_stall_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");
    a_no_back2back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("two results in consecutive cycles");
endmodule

bind rns_fast_basis_conversion_core rnsfbc_checker u_checker (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall, .o_converted
);
